// ===== rtl/vmmio_pkg.sv =====
// vmmio_pkg: shared types, register-map constants and helpers for the
// virtio-mmio transport register file; used by vmmio_ctrl and the top level.
package vmmio_pkg;

    // default configuration of the top level
    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_MAX_QUEUES = 8;

    // window word indexes (byte offset >> 2)
    localparam logic [5:0] W_MAGIC        = 6'h00;
    localparam logic [5:0] W_VERSION      = 6'h01;
    localparam logic [5:0] W_DEVICE_ID    = 6'h02;
    localparam logic [5:0] W_VENDOR       = 6'h03;
    localparam logic [5:0] W_DEV_FEAT     = 6'h04;
    localparam logic [5:0] W_SEL_GEN      = 6'h07;
    localparam logic [5:0] W_QUEUE_SEL    = 6'h0C;
    localparam logic [5:0] W_NUM_MAX      = 6'h0D;
    localparam logic [5:0] W_QUEUE_NUM    = 6'h0E;
    localparam logic [5:0] W_QUEUE_READY  = 6'h11;
    localparam logic [5:0] W_QUEUE_NOTIFY = 6'h14;
    localparam logic [5:0] W_STATUS       = 6'h1C;
    localparam logic [5:0] W_DESC_LO      = 6'h20;
    localparam logic [5:0] W_DESC_HI      = 6'h21;
    localparam logic [5:0] W_DRV_LO       = 6'h24;
    localparam logic [5:0] W_DRV_HI       = 6'h25;
    localparam logic [5:0] W_DEV_LO       = 6'h28;
    localparam logic [5:0] W_DEV_HI       = 6'h29;

    // shadow word of the ready register
    localparam logic [2:0] SH_READY = 3'd1;

    // fixed register values
    localparam logic [31:0] MAGIC_VALUE   = 32'h74726976;
    localparam logic [31:0] VERSION_VALUE = 32'h00000002;
    localparam logic [31:0] NOTIFY_IDLE   = 32'hFFFFFFFF;
    localparam logic [31:0] FEATURE_V1    = 32'h00000001;
    localparam logic [15:0] RESET_QSIZE   = 16'd256;

    // device ids per slot type
    localparam logic [31:0] DEVID_BLOCK   = 32'd2;
    localparam logic [31:0] DEVID_NET     = 32'd1;
    localparam logic [31:0] DEVID_CONSOLE = 32'd3;
    localparam logic [31:0] DEVID_ENTROPY = 32'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_VENDOR   = 3'd0;
    localparam logic [2:0] CFG_QSIZE    = 3'd1;
    localparam logic [2:0] CFG_Q_BLOCK  = 3'd2;
    localparam logic [2:0] CFG_Q_NET    = 3'd3;
    localparam logic [2:0] CFG_Q_CONS   = 3'd4;
    localparam logic [2:0] CFG_Q_ENTR   = 3'd5;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot_index;
        logic [7:0]  reg_offset;
        logic [31:0] write_data;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic        kick_valid;
        logic [3:0]  kick_slot;
        logic [15:0] kick_queue;
        logic [31:0] kick_sequence;
        logic [31:0] kick_epoch;
    } t_result;

    typedef struct packed {
        logic [31:0] vendor_ident;
        logic [15:0] queue_size_max;
        logic [3:0]  queues_block;
        logic [3:0]  queues_network;
        logic [3:0]  queues_console;
        logic [3:0]  queues_entropy;
    } t_cfg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SEL_NUM,
        S_SEL_MAX,
        S_CLR_SLOT,
        S_CLR_QUEUE
    } t_state;

    // shadow word of a setup register: bit 3 set means none
    function automatic logic [3:0] setup_index(input logic [5:0] w);
        logic [3:0] idx;
        unique case (w)
            W_QUEUE_NUM: idx = 4'd0;
            W_DESC_LO:   idx = 4'd2;
            W_DESC_HI:   idx = 4'd3;
            W_DRV_LO:    idx = 4'd4;
            W_DRV_HI:    idx = 4'd5;
            W_DEV_LO:    idx = 4'd6;
            W_DEV_HI:    idx = 4'd7;
            default:     idx = 4'd8;
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/vmmio_win_mem.sv =====
// vmmio_win_mem: visible register windows of all slots, one write port
// and two registered read ports; depends on nothing else.
module vmmio_win_mem #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [31:0]   o_rdata0,
    output logic [31:0]   o_rdata1
);

    logic [31:0] r_mem [2**AW];
    logic [31:0] r_rdata0;
    logic [31:0] r_rdata1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== rtl/vmmio_shadow_mem.sv =====
// vmmio_shadow_mem: per-queue setup shadow words of all slots, one write
// port and one registered read port; depends on nothing else.
module vmmio_shadow_mem #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [2**AW];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vmmio_ctrl.sv =====
// vmmio_ctrl: access sequencer; reads, modifies and writes back the window
// and shadow memories, holds slot epochs and the kick counter; uses vmmio_pkg.
module vmmio_ctrl #(
    parameter int NUM_SLOTS  = vmmio_pkg::DEF_NUM_SLOTS,
    parameter int MAX_QUEUES = vmmio_pkg::DEF_MAX_QUEUES,
    parameter int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    parameter int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vmmio_pkg::t_cfg      i_cfg,
    input  logic                 i_start,
    output logic                 o_busy,
    input  vmmio_pkg::t_access   i_access,
    output logic                 o_done,
    output vmmio_pkg::t_result   o_result,
    // window memory
    output logic                 o_win_we,
    output logic [SW+5:0]        o_win_waddr,
    output logic [31:0]          o_win_wdata,
    output logic [SW+5:0]        o_win_raddr0,
    output logic [SW+5:0]        o_win_raddr1,
    input  logic [31:0]          i_win_rdata0,
    input  logic [31:0]          i_win_rdata1,
    // shadow memory
    output logic                 o_sh_we,
    output logic [SW+QW+2:0]     o_sh_waddr,
    output logic [31:0]          o_sh_wdata,
    output logic [SW+QW+2:0]     o_sh_raddr,
    input  logic [31:0]          i_sh_rdata
);

    // sweep counter width over one slot: covers the larger of window and shadow
    localparam int LW = (QW + 3 > 6) ? QW + 3 : 6;

    vmmio_pkg::t_state  r_state, n_state;
    logic               r_op;
    logic [3:0]         r_slot;
    logic [5:0]         r_w;
    logic [31:0]        r_data;
    logic               r_ok;
    logic [QW-1:0]      r_qsel, n_qsel;
    logic [31:0]        r_num, n_num;
    logic [LW-1:0]      r_cnt, n_cnt;
    logic [SW-1:0]      r_init_slot, n_init_slot;
    logic [31:0]        r_kick, n_kick;
    logic               r_done, n_done;
    vmmio_pkg::t_result r_res, n_res;

    // slot epoch store
    logic [31:0]        r_epoch_mem [2**SW];
    logic [31:0]        r_epoch_rd;
    logic               ep_we;
    logic [SW-1:0]      ep_waddr;
    logic [31:0]        ep_wdata;

    logic               accept;
    logic [SW-1:0]      slot_a;
    logic [31:0]        sel;
    logic               sel_ok;
    logic [3:0]         qcount;
    logic [3:0]         sidx;
    logic [31:0]        rd_val;

    assign accept = i_start && (r_state == vmmio_pkg::S_IDLE);
    assign o_busy = (r_state != vmmio_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;
    assign slot_a = SW'(r_slot);

    // read addresses come straight from the access being accepted
    assign o_win_raddr0 = {SW'(i_access.slot_index), i_access.reg_offset[7:2]};
    assign o_win_raddr1 = {SW'(i_access.slot_index), vmmio_pkg::W_QUEUE_SEL};
    assign o_sh_raddr   = {SW'(i_access.slot_index), i_access.write_data[QW-1:0], 3'd0};

    // capture of the accepted access
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_access.op;
            r_slot <= i_access.slot_index;
            r_w    <= i_access.reg_offset[7:2];
            r_data <= i_access.write_data;
            r_ok   <= ({28'd0, i_access.slot_index} < 32'(NUM_SLOTS));
        end
    end

    // epoch store, written and read in a clocked block
    always_ff @(posedge i_clk) begin
        if (ep_we) begin
            r_epoch_mem[ep_waddr] <= ep_wdata;
        end
        r_epoch_rd <= r_epoch_mem[SW'(i_access.slot_index)];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vmmio_pkg::S_INIT;
            r_cnt       <= '0;
            r_init_slot <= '0;
            r_kick      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_init_slot <= n_init_slot;
            r_kick      <= n_kick;
            r_done      <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_qsel <= n_qsel;
        r_num  <= n_num;
        r_res  <= n_res;
    end

    // selected queue of this slot and its queue count
    assign sel    = i_win_rdata1;
    assign sel_ok = (sel < 32'(MAX_QUEUES));
    assign sidx   = vmmio_pkg::setup_index(r_w);

    always_comb begin
        unique case (r_slot[1:0])
            2'd0: qcount = i_cfg.queues_block;
            2'd1: qcount = i_cfg.queues_network;
            2'd2: qcount = i_cfg.queues_console;
            default: qcount = i_cfg.queues_entropy;
        endcase
    end

    // read value decode
    always_comb begin
        unique case (r_w)
            vmmio_pkg::W_MAGIC:        rd_val = vmmio_pkg::MAGIC_VALUE;
            vmmio_pkg::W_VERSION:      rd_val = vmmio_pkg::VERSION_VALUE;
            vmmio_pkg::W_DEVICE_ID: begin
                unique case (r_slot[1:0])
                    2'd0: rd_val = vmmio_pkg::DEVID_BLOCK;
                    2'd1: rd_val = vmmio_pkg::DEVID_NET;
                    2'd2: rd_val = vmmio_pkg::DEVID_CONSOLE;
                    default: rd_val = vmmio_pkg::DEVID_ENTROPY;
                endcase
            end
            vmmio_pkg::W_VENDOR:       rd_val = i_cfg.vendor_ident;
            vmmio_pkg::W_DEV_FEAT:     rd_val = vmmio_pkg::FEATURE_V1;
            vmmio_pkg::W_QUEUE_READY:  rd_val = '0;
            vmmio_pkg::W_QUEUE_NOTIFY: rd_val = vmmio_pkg::NOTIFY_IDLE;
            default:                   rd_val = i_win_rdata0;
        endcase
    end

    // next state, memory writes and result
    always_comb begin
        n_state     = r_state;
        n_qsel      = r_qsel;
        n_num       = r_num;
        n_cnt       = r_cnt;
        n_init_slot = r_init_slot;
        n_kick      = r_kick;
        n_done      = 1'b0;
        n_res       = r_res;
        o_win_we    = 1'b0;
        o_win_waddr = {slot_a, r_w};
        o_win_wdata = r_data;
        o_sh_we     = 1'b0;
        o_sh_waddr  = {slot_a, sel[QW-1:0], sidx[2:0]};
        o_sh_wdata  = r_data;
        ep_we       = 1'b0;
        ep_waddr    = slot_a;
        ep_wdata    = '0;

        unique case (r_state)
            // power-on sweep, one slot after another
            vmmio_pkg::S_INIT: begin
                o_win_we    = ((r_cnt >> 6) == '0);
                o_win_waddr = {r_init_slot, r_cnt[5:0]};
                o_win_wdata = (r_cnt[5:0] == vmmio_pkg::W_NUM_MAX) ?
                              {16'd0, vmmio_pkg::RESET_QSIZE} : 32'd0;
                o_sh_we     = ((r_cnt >> (QW + 3)) == '0);
                o_sh_waddr  = r_cnt[QW+2:0] + {r_init_slot, {(QW+3){1'b0}}};
                o_sh_wdata  = '0;
                ep_we       = (r_cnt == '0);
                ep_waddr    = r_init_slot;
                n_cnt       = r_cnt + 1'b1;
                if (&r_cnt) begin
                    if (r_init_slot == SW'(NUM_SLOTS - 1)) begin
                        n_state = vmmio_pkg::S_IDLE;
                    end else begin
                        n_init_slot = r_init_slot + 1'b1;
                    end
                end
            end

            vmmio_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = vmmio_pkg::S_EXEC;
                end
            end

            // memory words are in; decide and write back
            vmmio_pkg::S_EXEC: begin
                n_state = vmmio_pkg::S_IDLE;
                n_done  = 1'b1;
                n_res   = '0;
                n_qsel  = sel[QW-1:0];
                n_cnt   = '0;
                if (!r_ok) begin
                    n_res = '0;
                end else if (!r_op) begin
                    n_res.read_data = rd_val;
                end else begin
                    unique case (r_w)
                        vmmio_pkg::W_MAGIC, vmmio_pkg::W_VERSION,
                        vmmio_pkg::W_DEVICE_ID, vmmio_pkg::W_VENDOR,
                        vmmio_pkg::W_DEV_FEAT, vmmio_pkg::W_NUM_MAX: begin
                            n_res = '0;
                        end
                        vmmio_pkg::W_QUEUE_SEL: begin
                            o_win_we = 1'b1;
                            if (r_data < 32'(MAX_QUEUES)) begin
                                n_num   = i_sh_rdata;
                                n_done  = 1'b0;
                                n_state = vmmio_pkg::S_SEL_NUM;
                            end
                        end
                        vmmio_pkg::W_QUEUE_READY: begin
                            if (sel_ok) begin
                                o_sh_we    = 1'b1;
                                o_sh_waddr = {slot_a, sel[QW-1:0], vmmio_pkg::SH_READY};
                                if (r_data == '0) begin
                                    n_done  = 1'b0;
                                    n_state = vmmio_pkg::S_CLR_QUEUE;
                                end
                            end
                        end
                        vmmio_pkg::W_QUEUE_NOTIFY: begin
                            n_res.kick_valid    = 1'b1;
                            n_res.kick_slot     = r_slot;
                            n_res.kick_queue    = r_data[15:0];
                            n_res.kick_sequence = r_kick;
                            n_res.kick_epoch    = r_epoch_rd;
                            n_kick              = r_kick + 1'b1;
                        end
                        vmmio_pkg::W_STATUS: begin
                            if (r_data == '0) begin
                                ep_we    = 1'b1;
                                ep_wdata = r_epoch_rd + 1'b1;
                                n_done   = 1'b0;
                                n_state  = vmmio_pkg::S_CLR_SLOT;
                            end else begin
                                o_win_we = 1'b1;
                            end
                        end
                        vmmio_pkg::W_SEL_GEN: begin
                            o_win_we    = 1'b1;
                            o_win_wdata = r_data + 1'b1;
                        end
                        default: begin
                            o_win_we = 1'b1;
                            o_sh_we  = !sidx[3] && sel_ok;
                        end
                    endcase
                end
            end

            // queue select: load queue num from the shadow
            vmmio_pkg::S_SEL_NUM: begin
                o_win_we    = 1'b1;
                o_win_waddr = {slot_a, vmmio_pkg::W_QUEUE_NUM};
                o_win_wdata = r_num;
                n_state     = vmmio_pkg::S_SEL_MAX;
            end

            // queue select: queue num max for existing queues
            vmmio_pkg::S_SEL_MAX: begin
                o_win_we    = 1'b1;
                o_win_waddr = {slot_a, vmmio_pkg::W_NUM_MAX};
                o_win_wdata = (r_data < {28'd0, qcount}) ?
                              {16'd0, i_cfg.queue_size_max} : 32'd0;
                n_done      = 1'b1;
                n_state     = vmmio_pkg::S_IDLE;
            end

            // status zero: sweep the slot window and shadow
            vmmio_pkg::S_CLR_SLOT: begin
                o_win_we    = ((r_cnt >> 6) == '0);
                o_win_waddr = {slot_a, r_cnt[5:0]};
                o_win_wdata = (r_cnt[5:0] == vmmio_pkg::W_NUM_MAX) ?
                              {16'd0, i_cfg.queue_size_max} : 32'd0;
                o_sh_we     = ((r_cnt >> (QW + 3)) == '0);
                o_sh_waddr  = r_cnt[QW+2:0] + {slot_a, {(QW+3){1'b0}}};
                o_sh_wdata  = '0;
                n_cnt       = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_done  = 1'b1;
                    n_state = vmmio_pkg::S_IDLE;
                end
            end

            // ready zero: clear the eight shadow words of the queue
            vmmio_pkg::S_CLR_QUEUE: begin
                o_sh_we    = 1'b1;
                o_sh_waddr = {slot_a, r_qsel, r_cnt[2:0]};
                o_sh_wdata = '0;
                n_cnt      = r_cnt + 1'b1;
                if (&r_cnt[2:0]) begin
                    n_done  = 1'b1;
                    n_state = vmmio_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = vmmio_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/virtio_mmio_transport_regs.sv =====
// virtio_mmio_transport_regs: top level; configuration registers and the
// window, shadow and sequencer instances; uses vmmio_pkg and all rtl modules.
//
// Virtio-mmio version 2 register file for NUM_SLOTS device slots. An access
// is taken at a clock edge with start high and busy low; its one result is
// shown for a single cycle with o_done high and must be taken then, there is
// no back-pressure. A plain access passes a registered memory read and then
// a write-back before the next start is taken. A queue-select write of a
// queue below MAX_QUEUES also writes queue num and queue num max (three
// window words are written through the single window write port), a
// ready write of zero with such a queue selected clears eight shadow words
// one per cycle, a status write of zero sweeps the slot, one window and one
// shadow word per cycle. After reset the block sweeps both memories and is
// busy meanwhile; configuration writes are taken during that sweep.
module virtio_mmio_transport_regs #(
    parameter int NUM_SLOTS  = vmmio_pkg::DEF_NUM_SLOTS,
    parameter int MAX_QUEUES = vmmio_pkg::DEF_MAX_QUEUES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  vmmio_pkg::t_access i_access,
    output logic               o_done,
    output vmmio_pkg::t_result o_result
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

    vmmio_pkg::t_cfg r_cfg;

    logic            win_we;
    logic [SW+5:0]   win_waddr, win_raddr0, win_raddr1;
    logic [31:0]     win_wdata, win_rdata0, win_rdata1;
    logic            sh_we;
    logic [SW+QW+2:0] sh_waddr, sh_raddr;
    logic [31:0]     sh_wdata, sh_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vendor_ident   <= '0;
            r_cfg.queue_size_max <= vmmio_pkg::RESET_QSIZE;
            r_cfg.queues_block   <= 4'd1;
            r_cfg.queues_network <= 4'd2;
            r_cfg.queues_console <= 4'd2;
            r_cfg.queues_entropy <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vmmio_pkg::CFG_VENDOR: r_cfg.vendor_ident   <= i_cfg_data;
                vmmio_pkg::CFG_QSIZE:  r_cfg.queue_size_max <= i_cfg_data[15:0];
                vmmio_pkg::CFG_Q_BLOCK: r_cfg.queues_block  <= i_cfg_data[3:0];
                vmmio_pkg::CFG_Q_NET:  r_cfg.queues_network <= i_cfg_data[3:0];
                vmmio_pkg::CFG_Q_CONS: r_cfg.queues_console <= i_cfg_data[3:0];
                vmmio_pkg::CFG_Q_ENTR: r_cfg.queues_entropy <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // visible register windows
    vmmio_win_mem #(.AW(SW + 6)) u_win (
        .i_clk    (i_clk),
        .i_we     (win_we),
        .i_waddr  (win_waddr),
        .i_wdata  (win_wdata),
        .i_raddr0 (win_raddr0),
        .i_raddr1 (win_raddr1),
        .o_rdata0 (win_rdata0),
        .o_rdata1 (win_rdata1)
    );

    // per-queue setup shadow
    vmmio_shadow_mem #(.AW(SW + QW + 3)) u_shadow (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (sh_waddr),
        .i_wdata (sh_wdata),
        .i_raddr (sh_raddr),
        .o_rdata (sh_rdata)
    );

    // access sequencer
    vmmio_ctrl #(
        .NUM_SLOTS  (NUM_SLOTS),
        .MAX_QUEUES (MAX_QUEUES),
        .SW         (SW),
        .QW         (QW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_start      (start),
        .o_busy       (busy),
        .i_access     (i_access),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_win_we     (win_we),
        .o_win_waddr  (win_waddr),
        .o_win_wdata  (win_wdata),
        .o_win_raddr0 (win_raddr0),
        .o_win_raddr1 (win_raddr1),
        .i_win_rdata0 (win_rdata0),
        .i_win_rdata1 (win_rdata1),
        .o_sh_we      (sh_we),
        .o_sh_waddr   (sh_waddr),
        .o_sh_wdata   (sh_wdata),
        .o_sh_raddr   (sh_raddr),
        .i_sh_rdata   (sh_rdata)
    );

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a transfer in progress");

    // an accepted transfer makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // kick fields are zero on a result without a kick
    a_kick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.kick_valid) |-> (o_result.kick_sequence == '0 &&
        o_result.kick_epoch == '0 && o_result.kick_queue == '0 &&
        o_result.kick_slot == '0))
        else $error("kick fields set without a kick");

endmodule

// ===== bench/vmmio_access_checker.sv =====
// vmmio_access_checker: watches the access, result and configuration ports of
// the virtio-mmio register file, predicts every result and compares it.
// Depends on vmmio_pkg for the transfer structs and register-map constants.
module vmmio_access_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_start,
    input  logic                i_busy,
    input  vmmio_pkg::t_access  i_access,
    input  logic                i_done,
    input  vmmio_pkg::t_result  i_result,
    output int                  o_pending,
    output int                  o_errors
);

    localparam int SLOTS = 16;
    localparam int QUEUES = 8;
    localparam int QWORDS = 8;

    // predictor state: visible windows, per-queue shadows, epochs, kick count
    logic [31:0] win [SLOTS][64];
    logic [31:0] shadow [SLOTS][QUEUES*QWORDS];
    logic [31:0] epoch [SLOTS];
    logic [31:0] kick_count;
    vmmio_pkg::t_cfg    cfg;
    vmmio_pkg::t_result expected_results[$];

    assign o_pending = expected_results.size();

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        o_errors++;
    endtask

    function automatic logic [31:0] queue_count(input logic [1:0] kind);
        case (kind)
            2'd0: return {28'b0, cfg.queues_block};
            2'd1: return {28'b0, cfg.queues_network};
            2'd2: return {28'b0, cfg.queues_console};
            default: return {28'b0, cfg.queues_entropy};
        endcase
    endfunction

    function automatic void clear_slot(input int s);
        for (int k = 0; k < 64; k++) begin
            win[s][k] = '0;
            shadow[s][k] = '0;
        end
        win[s][vmmio_pkg::W_NUM_MAX] = {16'b0, cfg.queue_size_max};
    endfunction

    // apply one access to the predicted state and return its result
    function automatic vmmio_pkg::t_result apply_access(input vmmio_pkg::t_access a);
        vmmio_pkg::t_result r;
        int s;
        logic [5:0] w;
        logic [31:0] d;
        logic [31:0] sel;
        logic [3:0] si;
        int base;
        r = '0;
        s = a.slot_index;
        w = a.reg_offset[7:2];
        d = a.write_data;
        sel = win[s][vmmio_pkg::W_QUEUE_SEL];
        base = (sel < QUEUES) ? int'(sel) * QWORDS : -1;
        if (!a.op) begin
            case (w)
                vmmio_pkg::W_MAGIC:        r.read_data = vmmio_pkg::MAGIC_VALUE;
                vmmio_pkg::W_VERSION:      r.read_data = vmmio_pkg::VERSION_VALUE;
                vmmio_pkg::W_DEVICE_ID: begin
                    case (a.slot_index[1:0])
                        2'd0: r.read_data = vmmio_pkg::DEVID_BLOCK;
                        2'd1: r.read_data = vmmio_pkg::DEVID_NET;
                        2'd2: r.read_data = vmmio_pkg::DEVID_CONSOLE;
                        default: r.read_data = vmmio_pkg::DEVID_ENTROPY;
                    endcase
                end
                vmmio_pkg::W_VENDOR:       r.read_data = cfg.vendor_ident;
                vmmio_pkg::W_DEV_FEAT:     r.read_data = vmmio_pkg::FEATURE_V1;
                vmmio_pkg::W_QUEUE_READY:  r.read_data = '0;
                vmmio_pkg::W_QUEUE_NOTIFY: r.read_data = vmmio_pkg::NOTIFY_IDLE;
                default:                   r.read_data = win[s][w];
            endcase
            return r;
        end
        case (w)
            vmmio_pkg::W_MAGIC, vmmio_pkg::W_VERSION, vmmio_pkg::W_DEVICE_ID,
            vmmio_pkg::W_VENDOR, vmmio_pkg::W_DEV_FEAT, vmmio_pkg::W_NUM_MAX: ;
            vmmio_pkg::W_QUEUE_SEL: begin
                win[s][vmmio_pkg::W_QUEUE_SEL] = d;
                if (d < QUEUES) begin
                    win[s][vmmio_pkg::W_QUEUE_NUM] = shadow[s][int'(d) * QWORDS];
                    win[s][vmmio_pkg::W_NUM_MAX] = (d < queue_count(a.slot_index[1:0])) ?
                                                   {16'b0, cfg.queue_size_max} : '0;
                    win[s][vmmio_pkg::W_QUEUE_READY] = '0;
                end
            end
            vmmio_pkg::W_QUEUE_READY: begin
                if (base >= 0) begin
                    shadow[s][base + vmmio_pkg::SH_READY] = d;
                    if (d == '0) begin
                        for (int k = 0; k < QWORDS; k++) begin
                            if (k != vmmio_pkg::SH_READY) shadow[s][base + k] = '0;
                        end
                    end
                end
            end
            vmmio_pkg::W_QUEUE_NOTIFY: begin
                r.kick_valid = 1'b1;
                r.kick_slot = a.slot_index;
                r.kick_queue = d[15:0];
                r.kick_sequence = kick_count;
                r.kick_epoch = epoch[s];
                kick_count++;
            end
            vmmio_pkg::W_STATUS: begin
                if (d == '0) begin
                    clear_slot(s);
                    epoch[s]++;
                end else begin
                    win[s][vmmio_pkg::W_STATUS] = d;
                end
            end
            vmmio_pkg::W_SEL_GEN: win[s][vmmio_pkg::W_SEL_GEN] = d + 1;
            default: begin
                win[s][w] = d;
                si = vmmio_pkg::setup_index(w);
                if (!si[3] && base >= 0) shadow[s][base + si] = d;
            end
        endcase
        return r;
    endfunction

    // compare a result transfer with the oldest prediction
    task automatic check_result(input vmmio_pkg::t_result got);
        vmmio_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report("unexpected result", got.read_data, '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
        if (got.kick_valid !== want.kick_valid)
            report("kick_valid", got.kick_valid, want.kick_valid);
        if (got.kick_slot !== want.kick_slot) report("kick_slot", got.kick_slot, want.kick_slot);
        if (got.kick_queue !== want.kick_queue)
            report("kick_queue", got.kick_queue, want.kick_queue);
        if (got.kick_sequence !== want.kick_sequence)
            report("kick_sequence", got.kick_sequence, want.kick_sequence);
        if (got.kick_epoch !== want.kick_epoch)
            report("kick_epoch", got.kick_epoch, want.kick_epoch);
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{vendor_ident: '0, queue_size_max: vmmio_pkg::RESET_QSIZE,
                    queues_block: 4'd1, queues_network: 4'd2, queues_console: 4'd2,
                    queues_entropy: 4'd1};
            for (int s = 0; s < SLOTS; s++) begin
                clear_slot(s);
                epoch[s] = '0;
            end
            kick_count = '0;
            o_errors = 0;
            expected_results.delete();
        end else begin
            if (i_done) check_result(i_result);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vmmio_pkg::CFG_VENDOR:  cfg.vendor_ident = i_cfg_data;
                    vmmio_pkg::CFG_QSIZE:   cfg.queue_size_max = i_cfg_data[15:0];
                    vmmio_pkg::CFG_Q_BLOCK: cfg.queues_block = i_cfg_data[3:0];
                    vmmio_pkg::CFG_Q_NET:   cfg.queues_network = i_cfg_data[3:0];
                    vmmio_pkg::CFG_Q_CONS:  cfg.queues_console = i_cfg_data[3:0];
                    vmmio_pkg::CFG_Q_ENTR:  cfg.queues_entropy = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) expected_results.push_back(apply_access(i_access));
        end
    end

endmodule

// ===== bench/virtio_mmio_transport_regs_tb.sv =====
// virtio_mmio_transport_regs_tb: drives directed and random bus accesses and
// configuration phases into the register file; vmmio_access_checker judges.
// Depends on vmmio_pkg, the rtl modules and bench/vmmio_access_checker.sv.
module virtio_mmio_transport_regs_tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = vmmio_pkg::CFG_VENDOR;
    logic [31:0]        i_cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    vmmio_pkg::t_access i_access = '0;
    logic               o_done;
    vmmio_pkg::t_result o_result;
    int                 pending;
    int                 errors;
    int                 sent = 0;
    bit                 quiet = 1'b0;

    localparam int TOTAL_ITEMS = 1050;

    always #4 i_clk = ~i_clk;

    virtio_mmio_transport_regs DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .start, .busy, .i_access, .o_done, .o_result
    );

    vmmio_access_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_start(start), .i_busy(busy), .i_access, .i_done(o_done),
        .i_result(o_result), .o_pending(pending), .o_errors(errors)
    );

    function automatic vmmio_pkg::t_access mk(input logic op, input logic [3:0] slot,
                                              input logic [7:0] off,
                                              input logic [31:0] data);
        vmmio_pkg::t_access a;
        a.op = op;
        a.slot_index = slot;
        a.reg_offset = off;
        a.write_data = data;
        return a;
    endfunction

    // hold start until the transfer is taken, then maybe idle a burst
    task automatic send(input vmmio_pkg::t_access a);
        i_access <= a;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] vendor, input logic [15:0] qsize,
                             input logic [3:0] qb, input logic [3:0] qn,
                             input logic [3:0] qc, input logic [3:0] qe);
        cfg_write(vmmio_pkg::CFG_VENDOR, vendor);
        cfg_write(vmmio_pkg::CFG_QSIZE, {16'b0, qsize});
        cfg_write(vmmio_pkg::CFG_Q_BLOCK, {28'b0, qb});
        cfg_write(vmmio_pkg::CFG_Q_NET, {28'b0, qn});
        cfg_write(vmmio_pkg::CFG_Q_CONS, {28'b0, qc});
        cfg_write(vmmio_pkg::CFG_Q_ENTR, {28'b0, qe});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_offset();
        logic [5:0] words [14] = '{vmmio_pkg::W_MAGIC, vmmio_pkg::W_DEVICE_ID,
            vmmio_pkg::W_VENDOR, vmmio_pkg::W_SEL_GEN, vmmio_pkg::W_QUEUE_SEL,
            vmmio_pkg::W_NUM_MAX, vmmio_pkg::W_QUEUE_NUM, vmmio_pkg::W_QUEUE_READY,
            vmmio_pkg::W_QUEUE_NOTIFY, vmmio_pkg::W_STATUS, vmmio_pkg::W_DESC_LO,
            vmmio_pkg::W_DEV_HI, vmmio_pkg::W_DRV_LO, vmmio_pkg::W_DEV_FEAT};
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return {words[$urandom_range(0, 13)], 2'($urandom)};
    endfunction

    // one random access; frequent zero writes to status and ready
    task automatic random_access();
        vmmio_pkg::t_access a;
        a = mk(1'($urandom), 4'($urandom), pick_offset(), $urandom);
        if (a.reg_offset[7:2] == vmmio_pkg::W_QUEUE_SEL && $urandom_range(0, 3) != 0)
            a.write_data = $urandom_range(0, 9);
        if (a.reg_offset[7:2] == vmmio_pkg::W_STATUS && $urandom_range(0, 2) != 0)
            a.write_data = $urandom_range(0, 1) ? 32'd0 : 32'd15;
        if (a.reg_offset[7:2] == vmmio_pkg::W_QUEUE_READY && $urandom_range(0, 1) == 0)
            a.write_data = '0;
        send(a);
    endtask

    // well-formed queue setup: select, size, addresses, ready, read-back, notify
    task automatic queue_setup();
        logic [3:0] s;
        logic [31:0] q;
        s = 4'($urandom);
        q = $urandom_range(0, 9);
        send(mk(1'b1, s, {vmmio_pkg::W_QUEUE_SEL, 2'b00}, q));
        send(mk(1'b0, s, {vmmio_pkg::W_NUM_MAX, 2'b00}, $urandom));
        send(mk(1'b1, s, {vmmio_pkg::W_QUEUE_NUM, 2'b00}, $urandom_range(0, 1024)));
        send(mk(1'b1, s, {vmmio_pkg::W_DESC_LO, 2'b00}, $urandom));
        send(mk(1'b1, s, {vmmio_pkg::W_DRV_HI, 2'b00}, $urandom));
        send(mk(1'b1, s, {vmmio_pkg::W_DEV_LO, 2'b00}, $urandom));
        send(mk(1'b1, s, {vmmio_pkg::W_QUEUE_READY, 2'b00},
                $urandom_range(0, 4) == 0 ? 0 : 1));
        send(mk(1'b1, s, {vmmio_pkg::W_QUEUE_SEL, 2'b00}, $urandom_range(0, 9)));
        send(mk(1'b1, s, {vmmio_pkg::W_QUEUE_SEL, 2'b00}, q));
        send(mk(1'b0, s, {vmmio_pkg::W_QUEUE_NUM, 2'b00}, $urandom));
        send(mk(1'b0, s, {vmmio_pkg::W_DESC_LO, 2'b00}, $urandom));
        send(mk(1'b1, s, {vmmio_pkg::W_QUEUE_NOTIFY, 2'b00}, $urandom));
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at) begin
            if (sent > TOTAL_ITEMS - 150) quiet = 1'b1;
            if ($urandom_range(0, 9) < 6) queue_setup();
            else random_access();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        configure(32'h1AF4_0000, 16'd256, 4'd1, 4'd2, 4'd2, 4'd1);

        // directed: identity reads, read-only writes, select edges, special writes
        send(mk(1'b0, 4'd0, 8'h00, '0));
        send(mk(1'b0, 4'd1, 8'h05, '0));
        send(mk(1'b0, 4'd2, 8'h0B, '0));
        send(mk(1'b0, 4'd15, 8'h0C, '0));
        send(mk(1'b0, 4'd3, 8'h10, '0));
        send(mk(1'b1, 4'd0, 8'h00, 32'hFFFF_FFFF));
        send(mk(1'b1, 4'd0, 8'h34, 32'h1234));
        send(mk(1'b0, 4'd0, 8'h00, '0));
        send(mk(1'b1, 4'd1, 8'h30, 32'd1));
        send(mk(1'b0, 4'd1, 8'h34, '0));
        send(mk(1'b1, 4'd1, 8'h38, 32'hFFFF_FFFF));
        send(mk(1'b1, 4'd1, 8'h80, 32'hDEAD_BEEF));
        send(mk(1'b1, 4'd1, 8'h44, 32'd1));
        send(mk(1'b1, 4'd1, 8'h30, 32'd7));
        send(mk(1'b1, 4'd1, 8'h30, 32'd8));
        send(mk(1'b1, 4'd1, 8'h30, 32'hFFFF_FFFF));
        send(mk(1'b1, 4'd1, 8'h30, 32'd1));
        send(mk(1'b0, 4'd1, 8'h38, '0));
        send(mk(1'b1, 4'd1, 8'h44, '0));
        send(mk(1'b1, 4'd14, 8'h50, 32'hFFFF_FFFF));
        send(mk(1'b1, 4'd14, 8'h53, '0));
        send(mk(1'b1, 4'd14, 8'h70, 32'h8000_0000));
        send(mk(1'b1, 4'd14, 8'h70, '0));
        send(mk(1'b1, 4'd14, 8'h1C, 32'hFFFF_FFFF));
        send(mk(1'b0, 4'd14, 8'hFF, '0));
        random_phase(220);
        wait_idle();

        // size 32768 and eight queues per slot type
        configure(32'hFFFF_FFFF, 16'd32768, 4'd8, 4'd8, 4'd8, 4'd8);
        random_phase(270);
        wait_idle();

        // everything zero
        configure(32'h0, 16'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        random_phase(250);
        wait_idle();

        configure($urandom, 16'($urandom_range(0, 32768)), 4'($urandom_range(0, 8)),
                  4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)));
        random_phase(TOTAL_ITEMS - sent);
        wait_idle();

        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vmmio_pkg.sv
rtl/vmmio_win_mem.sv
rtl/vmmio_shadow_mem.sv
rtl/vmmio_ctrl.sv
rtl/virtio_mmio_transport_regs.sv
bench/vmmio_access_checker.sv
bench/virtio_mmio_transport_regs_tb.sv
